// File: hdl/vmab_pkg.sv
// Package with shared types and constants for the velocity filter.
`timescale 1ns / 1ps
package vmab_pkg;

  localparam int WindowDef  = 5;
  localparam int VelWidthDef = 16;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxWidth = 3;

  // Command codes of an input request.
  localparam logic [1:0] CmdImu  = 2'd0;
  localparam logic [1:0] CmdPose = 2'd1;
  localparam logic [1:0] CmdTick = 2'd2;

  // Source codes of a result.
  localparam logic [1:0] SrcImu  = 2'd0;
  localparam logic [1:0] SrcPose = 2'd1;
  localparam logic [1:0] SrcNone = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] RegImuTimeout  = 3'd0;
  localparam logic [2:0] RegPoseTimeout = 3'd1;
  localparam logic [2:0] RegAlpha       = 3'd2;
  localparam logic [2:0] RegTickPeriod  = 3'd3;
  localparam logic [2:0] RegBetaOverDt  = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StSort,
    StPred,
    StCorr,
    StSqrt,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // select source, push window
    logic sort_step; // one rank-counting step of the median
    logic pred;      // prediction and residual
    logic corr;      // correction and state update
    logic sqrt_init; // load the root unit
    logic sqrt_step; // one root iteration
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_done;
    logic sqrt_done;
  } sts_t;

endpackage

// File: hdl/velocity_median_alpha_beta_filter.sv
// Top level: input request intake, controller, datapath and output register.
// A tick runs a median scan over the window (fill = window count after the push,
// 1 to Window), prediction, correction, the root iterations and an output load, which
// waits while the output is stalled; the next request is taken once the controller is
// idle again. IMU and pose requests give no result. Reset (asynchronous, active low)
// loads default gains, clears filter state, marks sources stale, empties windows.
`timescale 1ns / 1ps
module velocity_median_alpha_beta_filter
  import vmab_pkg::*;
#(
  parameter int Window   = WindowDef,
  parameter int VelWidth = VelWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [CfgWidth-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic signed [VelWidth-1:0] vel_x_i,
  input  logic signed [VelWidth-1:0] vel_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VelWidth-1:0] est_vel_x_o,
  output logic signed [VelWidth-1:0] est_vel_y_o,
  output logic [VelWidth-1:0]        speed_o,
  output logic [1:0]                 source_o,
  output logic                       any_alive_o
);

  cmd_t dp_cmd;
  sts_t dp_sts;
  logic busy, out_load, accept;
  logic signed [VelWidth-1:0] ex, ey;
  logic [VelWidth-1:0]        sp;
  logic [1:0]                 src;
  logic                       alive;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  vmab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (accept && cmd_i == CmdTick),
    .out_busy_i (out_valid_o && out_stall_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd),
    .busy_o     (busy),
    .out_load_o (out_load)
  );

  vmab_dp #(
    .Window   (Window),
    .VelWidth (VelWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .latch_i    (accept),
    .in_cmd_i   (cmd_i),
    .in_vx_i    (vel_x_i),
    .in_vy_i    (vel_y_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .est_x_o    (ex),
    .est_y_o    (ey),
    .speed_o    (sp),
    .source_o   (src),
    .alive_o    (alive)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      est_vel_x_o <= ex;
      est_vel_y_o <= ey;
      speed_o     <= sp;
      source_o    <= src;
      any_alive_o <= alive;
    end
  end

endmodule

// File: hdl/vmab_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
`timescale 1ns / 1ps
module vmab_ctrl
  import vmab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  logic       out_busy_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       out_load_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    busy_o     = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (tick_i) begin
          cmd_o.start = 1'b1;
          state_d     = StSort;
        end
      end
      StSort: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_done) begin
          state_d = StPred;
        end
      end
      StPred: begin
        cmd_o.pred = 1'b1;
        state_d    = StCorr;
      end
      StCorr: begin
        cmd_o.corr = 1'b1;
        state_d    = StSqrt;
      end
      StSqrt: begin
        if (sts_i.sqrt_done) begin
          state_d = StOut;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      StOut: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StCorr) begin
      cmd_o.sqrt_init = 1'b1;
    end
  end

endmodule

// File: hdl/vmab_dp.sv
// Datapath: source selection, windows, median, alpha-beta filter and root.
`timescale 1ns / 1ps
module vmab_dp
  import vmab_pkg::*;
#(
  parameter int Window   = WindowDef,
  parameter int VelWidth = VelWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [CfgWidth-1:0]        cfg_data_i,
  input  logic                       latch_i,
  input  logic [1:0]                 in_cmd_i,
  input  logic signed [VelWidth-1:0] in_vx_i,
  input  logic signed [VelWidth-1:0] in_vy_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  output logic signed [VelWidth-1:0] est_x_o,
  output logic signed [VelWidth-1:0] est_y_o,
  output logic [VelWidth-1:0]        speed_o,
  output logic [1:0]                 source_o,
  output logic                       alive_o
);

  localparam int FiltW  = VelWidth + 8;
  localparam int AccW   = 32;
  localparam int FillW  = $clog2(Window + 1);
  localparam int IdxW   = (Window > 1) ? $clog2(Window) : 1;
  localparam int SqW    = 2 * VelWidth + 1;
  localparam int RootW  = VelWidth + 1;
  localparam int SqIter = (SqW + 1) / 2;
  localparam int ItW    = $clog2(SqIter + 2);
  localparam int WideW  = AccW + 18;

  // Configuration registers.
  logic [7:0]  imu_to_q, pose_to_q;
  logic [15:0] alpha_q, period_q, beta_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_to_q  <= 8'd25;
      pose_to_q <= 8'd25;
      alpha_q   <= 16'd45875;
      period_q  <= 16'd1311;
      beta_q    <= 16'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImuTimeout:  imu_to_q  <= cfg_data_i[7:0];
        RegPoseTimeout: pose_to_q <= cfg_data_i[7:0];
        RegAlpha:       alpha_q   <= cfg_data_i;
        RegTickPeriod:  period_q  <= cfg_data_i;
        RegBetaOverDt:  beta_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Held samples, ages and source selection.
  logic signed [VelWidth-1:0] imu_x_q, imu_y_q, pose_x_q, pose_y_q;
  logic                       imu_seen_q;
  logic [7:0]                 imu_age_q, pose_age_q;
  logic                       imu_fresh, pose_fresh, use_imu, use_pose;

  assign imu_fresh  = imu_age_q < imu_to_q;
  assign pose_fresh = pose_age_q < pose_to_q;
  assign use_imu    = imu_fresh && imu_seen_q;
  assign use_pose   = !use_imu && pose_fresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_x_q    <= '0;
      imu_y_q    <= '0;
      pose_x_q   <= '0;
      pose_y_q   <= '0;
      imu_seen_q <= 1'b0;
      imu_age_q  <= 8'hff;
      pose_age_q <= 8'hff;
    end else if (latch_i && in_cmd_i == CmdImu) begin
      imu_x_q    <= in_vx_i;
      imu_y_q    <= in_vy_i;
      imu_seen_q <= 1'b1;
      imu_age_q  <= '0;
    end else if (latch_i && in_cmd_i == CmdPose) begin
      pose_x_q   <= in_vx_i;
      pose_y_q   <= in_vy_i;
      pose_age_q <= '0;
    end else if (cmd_i.start) begin
      if (imu_age_q != 8'hff) imu_age_q <= imu_age_q + 8'd1;
      if (pose_age_q != 8'hff) pose_age_q <= pose_age_q + 8'd1;
    end
  end

  // Windows: oldest entry in slot 0, shifted out when full.
  logic signed [VelWidth-1:0] win_x_q [Window];
  logic signed [VelWidth-1:0] win_y_q [Window];
  logic [FillW-1:0]           fill_q;
  logic signed [VelWidth-1:0] tx, ty;
  logic [FillW-1:0]           fill_base;

  assign tx = use_imu ? imu_x_q : (use_pose ? pose_x_q : '0);
  assign ty = use_imu ? imu_y_q : (use_pose ? pose_y_q : '0);
  assign fill_base = (use_imu || use_pose) ? fill_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.start) begin
      fill_q <= (fill_base == FillW'(Window)) ? fill_base : fill_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (fill_base == FillW'(Window)) begin
        for (int i = 0; i < Window - 1; i++) begin
          win_x_q[i] <= win_x_q[i+1];
          win_y_q[i] <= win_y_q[i+1];
        end
        win_x_q[Window-1] <= tx;
        win_y_q[Window-1] <= ty;
      end else begin
        win_x_q[fill_base[IdxW-1:0]] <= tx;
        win_y_q[fill_base[IdxW-1:0]] <= ty;
      end
    end
  end

  // Median by rank counting, one candidate per cycle: the candidate whose
  // rank (ties broken by position) equals fill/2 is the median.
  logic [FillW-1:0]           cand_q;
  logic signed [VelWidth-1:0] med_x_q, med_y_q;
  logic signed [VelWidth-1:0] cx, cy;
  logic [FillW-1:0]           rank_x, rank_y, half;
  logic [IdxW-1:0]            cidx;

  assign cidx = cand_q[IdxW-1:0];
  assign cx   = win_x_q[cidx];
  assign cy   = win_y_q[cidx];
  assign half = fill_q >> 1;

  always_comb begin
    rank_x = '0;
    rank_y = '0;
    for (int j = 0; j < Window; j++) begin
      if (FillW'(j) < fill_q) begin
        if (win_x_q[j] < cx || (win_x_q[j] == cx && FillW'(j) < cand_q))
          rank_x = rank_x + 1'b1;
        if (win_y_q[j] < cy || (win_y_q[j] == cy && FillW'(j) < cand_q))
          rank_y = rank_y + 1'b1;
      end
    end
  end

  assign sts_o.sort_done = (cand_q == fill_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else if (cmd_i.start) begin
      cand_q <= '0;
    end else if (cmd_i.sort_step) begin
      cand_q <= cand_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_step) begin
      if (rank_x == half) med_x_q <= cx;
      if (rank_y == half) med_y_q <= cy;
    end
  end

  // Alpha-beta filter state.
  logic signed [FiltW-1:0] vel_x_q, vel_y_q;
  logic signed [AccW-1:0]  acc_x_q, acc_y_q;
  logic signed [WideW-1:0] pred_x_q, pred_y_q, res_x_q, res_y_q;
  logic [1:0]              src_q;
  logic                    alive_q;

  // Prediction: pred = vel + floor(acc*period/2^16); res = med*2^8 - pred.
  logic signed [WideW-1:0] px, py;
  assign px = WideW'(vel_x_q) + WideW'((WideW'(acc_x_q) * $signed({1'b0, period_q})) >>> 16);
  assign py = WideW'(vel_y_q) + WideW'((WideW'(acc_y_q) * $signed({1'b0, period_q})) >>> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q   <= use_imu ? SrcImu : (use_pose ? SrcPose : SrcNone);
      alive_q <= imu_fresh || pose_fresh;
    end
    if (cmd_i.pred) begin
      pred_x_q <= px;
      pred_y_q <= py;
      res_x_q  <= (WideW'(med_x_q) <<< 8) - px;
      res_y_q  <= (WideW'(med_y_q) <<< 8) - py;
    end
  end

  function automatic logic signed [FiltW-1:0] sat_f(input logic signed [WideW+16:0] v);
    logic signed [WideW+16:0] hi, lo;
    hi = $signed({{(WideW+17-FiltW){1'b0}}, 1'b0, {(FiltW-1){1'b1}}});
    lo = -hi - 1;
    return (v > hi) ? hi[FiltW-1:0] : ((v < lo) ? lo[FiltW-1:0] : v[FiltW-1:0]);
  endfunction

  function automatic logic signed [AccW-1:0] sat_a(input logic signed [WideW+16:0] v);
    logic signed [WideW+16:0] hi, lo;
    hi = $signed({{(WideW+17-AccW){1'b0}}, 1'b0, {(AccW-1){1'b1}}});
    lo = -hi - 1;
    return (v > hi) ? hi[AccW-1:0] : ((v < lo) ? lo[AccW-1:0] : v[AccW-1:0]);
  endfunction

  // Correction products.
  logic signed [WideW+16:0] nvx, nvy, nax, nay;
  assign nvx = (WideW+17)'(pred_x_q) +
               ((WideW+17)'(res_x_q) * $signed({1'b0, alpha_q}) >>> 16);
  assign nvy = (WideW+17)'(pred_y_q) +
               ((WideW+17)'(res_y_q) * $signed({1'b0, alpha_q}) >>> 16);
  assign nax = (WideW+17)'(acc_x_q) +
               ((WideW+17)'(res_x_q) * $signed({1'b0, beta_q}) >>> 8);
  assign nay = (WideW+17)'(acc_y_q) +
               ((WideW+17)'(res_y_q) * $signed({1'b0, beta_q}) >>> 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q <= '0;
      vel_y_q <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (cmd_i.start && !(use_imu || use_pose)) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (cmd_i.corr) begin
      vel_x_q <= sat_f(nvx);
      vel_y_q <= sat_f(nvy);
      acc_x_q <= sat_a(nax);
      acc_y_q <= sat_a(nay);
    end
  end

  assign est_x_o = vel_x_q[FiltW-1:8];
  assign est_y_o = vel_y_q[FiltW-1:8];

  // Iterative square root, one result bit per cycle.
  logic [SqW-1:0]   rem_q;
  logic [RootW-1:0] root_q;
  logic [ItW-1:0]   it_q;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_sh;
  logic [SqW-1:0]   sq_x, sq_y;
  logic [2*SqIter-1:0] rad_q;

  // Squares use the updated velocity after the correction cycle.
  assign sq_x = SqW'(est_x_o) * SqW'(est_x_o);
  assign sq_y = SqW'(est_y_o) * SqW'(est_y_o);
  assign rem_sh = {rem_q, rad_q[2*SqIter-1 -: 2]};
  assign trial  = (SqW+2)'({root_q, 2'b01});
  assign sts_o.sqrt_done = (it_q == '0);

  // The count covers the radicand load plus every root bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.sqrt_init) begin
      it_q <= ItW'(SqIter + 1);
    end else if (cmd_i.sqrt_step) begin
      it_q <= it_q - 1'b1;
    end
  end

  // The radicand is loaded in the cycle after the correction, via a flag.
  logic load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) load_q <= 1'b0;
    else         load_q <= cmd_i.sqrt_init;
  end

  always_ff @(posedge clk_i) begin
    if (load_q) begin
      rad_q  <= (2*SqIter)'(sq_x + sq_y);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= (SqW+2)'(trial)) begin
        rem_q  <= SqW'(rem_sh - (SqW+2)'(trial));
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= SqW'(rem_sh);
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign speed_o  = root_q[VelWidth-1:0];
  assign source_o = src_q;
  assign alive_o  = alive_q;

endmodule
